>>> rtl/assert_macros.svh
// Assertion helpers included by rational_arithmetic_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/rau_pkg.sv
package rau_pkg;

   localparam int WORD_BITS_DEF = 32;

   // Width of the shared add/subtract unit: 64-bit magnitudes plus sign and guard.
   localparam int AW = 66;

   localparam logic [3:0] FN_ADD  = 4'd0;
   localparam logic [3:0] FN_SUB  = 4'd1;
   localparam logic [3:0] FN_MUL  = 4'd2;
   localparam logic [3:0] FN_DIV  = 4'd3;
   localparam logic [3:0] FN_LT   = 4'd4;
   localparam logic [3:0] FN_LE   = 4'd5;
   localparam logic [3:0] FN_EQ   = 4'd6;
   localparam logic [3:0] FN_NE   = 4'd7;
   localparam logic [3:0] FN_GE   = 4'd8;
   localparam logic [3:0] FN_GT   = 4'd9;
   localparam logic [3:0] FN_NORM = 4'd10;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIV0 = 2'd1,
      ST_OVF  = 2'd2
   } status_type;

   // Control of the shared add/subtract unit.
   typedef struct packed {
      logic sub;
   } au_ctrl_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               cmp_true;
      status_type         status;
   } rsp_type;

endpackage

>>> rtl/rau_req_if.sv
interface rau_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         func;
   logic signed [31:0] a_num;
   logic signed [31:0] a_den;
   logic signed [31:0] b_num;
   logic [30:0]        b_den;

   modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

>>> rtl/rau_rsp_if.sv
interface rau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_num;
   logic [30:0]        res_den;
   logic               cmp_true;
   logic [1:0]         status;

   modport source (output valid, res_num, res_den, cmp_true, status, input ready);
   modport sink   (input valid, res_num, res_den, cmp_true, status, output ready);
endinterface

>>> rtl/rau_mul.sv
module rau_mul
   import rau_pkg::*;
(
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);
   // Unsigned 32 by 32 product; the caller registers it.
   assign product = {32'd0, op_a} * {32'd0, op_b};
endmodule

>>> rtl/rau_addsub.sv
module rau_addsub
   import rau_pkg::*;
(
   input  logic [AW-1:0] op_a,
   input  logic [AW-1:0] op_b,
   input  au_ctrl_type   ctrl,
   output logic [AW-1:0] sum
);
   // Two's complement add or subtract; a subtract inverts b and carries in one.
   assign sum = op_a + (op_b ^ {AW{ctrl.sub}}) + {{(AW-1){1'b0}}, ctrl.sub};
endmodule

>>> rtl/rational_arithmetic_unit.sv
// Channel   | Direction | Handshake              | Payload
// req_chan  | in        | valid / ready          | func, a_num, a_den, b_num, b_den
// rsp_chan  | out       | valid / ready          | res_num, res_den, cmp_true, status
//
// A request runs through three multiplies with sign fixup, combine and magnitude, a
// binary gcd (a swap costs a step of its own) and two 64-step restoring divisions, all
// on one shared 66-bit add/subtract unit. A bad code, a zero denominator or a zero
// divisor goes straight to the output, as do comparisons after the combine and a zero
// result after the magnitude. Reset is synchronous and active high; it clears the
// sequencer and the response valid. req_chan.ready is high only while the sequencer
// is idle. A finished response waits in the output register, so a new request can be
// taken while rsp_chan is stalled; the next response then waits until that one leaves.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   rau_req_if.sink   req_chan,
   rau_rsp_if.source rsp_chan
);

`include "assert_macros.svh"

   // Largest magnitude a reduced numerator or denominator may have.
   localparam logic [63:0] LIMIT = (64'd1 << (WORD_BITS - 1)) - 64'd1;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_SGN, S_COMB, S_ABS, S_GCD, S_DIVN, S_DIVD, S_PACK, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         func_ff, func_in;
   logic [31:0]        an_mag_ff, an_mag_in;
   logic               an_neg_ff, an_neg_in;
   logic [31:0]        bn_mag_ff, bn_mag_in;
   logic               bn_neg_ff, bn_neg_in;
   logic [31:0]        ad_ff, ad_in;
   logic [30:0]        bd_ff, bd_in;
   logic [1:0]         step_ff, step_in;
   logic [63:0]        p_ff, p_in;
   logic               psign_ff, psign_in;
   logic [AW-1:0]      x_ff, x_in;
   logic [AW-1:0]      y_ff, y_in;
   logic [63:0]        d_ff, d_in;
   logic               neg_ff, neg_in;
   logic [63:0]        m_ff, m_in;
   logic [63:0]        u_ff, u_in;
   logic [63:0]        v_ff, v_in;
   logic [5:0]         k_ff, k_in;
   logic [63:0]        rem_ff, rem_in;
   logic [63:0]        q_ff, q_in;
   logic [5:0]         cnt_ff, cnt_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [AW-1:0]      au_a, au_b, au_sum;
   au_ctrl_type        au_ctrl;

   rau_mul u_mul (.op_a(mul_a), .op_b(mul_b), .product(mul_p));
   rau_addsub u_addsub (.op_a(au_a), .op_b(au_b), .ctrl(au_ctrl), .sum(au_sum));

   localparam rsp_type RSP_ZERO = '{res_num: 32'sd0, res_den: 31'd1,
                                    cmp_true: 1'b0, status: ST_OK};

   logic req_fire;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.res_num = rsp_ff.res_num;
   assign rsp_chan.res_den = rsp_ff.res_den;
   assign rsp_chan.cmp_true = rsp_ff.cmp_true;
   assign rsp_chan.status  = rsp_ff.status;

   logic          is_addsub_cmp;
   logic          cmp_res;
   logic [64:0]   div_t;
   logic          div_last;
   logic [63:0]   q_shift;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      an_mag_in    = an_mag_ff;
      an_neg_in    = an_neg_ff;
      bn_mag_in    = bn_mag_ff;
      bn_neg_in    = bn_neg_ff;
      ad_in        = ad_ff;
      bd_in        = bd_ff;
      step_in      = step_ff;
      p_in         = p_ff;
      psign_in     = psign_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      m_in         = m_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      mul_a   = an_mag_ff;
      mul_b   = {1'b0, bd_ff};
      au_a    = '0;
      au_b    = '0;
      au_ctrl = '{sub: 1'b0};
      cmp_res = 1'b0;

      is_addsub_cmp = !(func_ff == FN_MUL || func_ff == FN_DIV || func_ff == FN_NORM);
      div_t    = {rem_ff, q_ff[63]};
      div_last = (cnt_ff == 6'd63);
      q_shift  = {q_ff[62:0], 1'b0};

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in   = req_chan.func;
               // Magnitudes and signs; the sign of a's denominator moves to a's numerator.
               an_mag_in = req_chan.a_num[31] ? (~req_chan.a_num + 32'd1) : req_chan.a_num;
               an_neg_in = req_chan.a_num[31] ^ req_chan.a_den[31];
               ad_in     = req_chan.a_den[31] ? (~req_chan.a_den + 32'd1) : req_chan.a_den;
               bn_mag_in = req_chan.b_num[31] ? (~req_chan.b_num + 32'd1) : req_chan.b_num;
               bn_neg_in = req_chan.b_num[31];
               bd_in     = req_chan.b_den;
               step_in   = 2'd0;
               pend_in   = RSP_ZERO;
               if (req_chan.func > FN_NORM) begin
                  state_in = S_OUT;
               end else if (req_chan.a_den == 32'sd0 ||
                            (req_chan.func != FN_NORM && req_chan.b_den == 31'd0) ||
                            (req_chan.func == FN_DIV && req_chan.b_num == 32'sd0)) begin
                  pend_in.status = ST_DIV0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_MUL;
               end
            end
         end

         S_MUL: begin
            // First the left cross term, then the right one, then the denominator.
            case (step_ff)
               2'd0: begin
                  mul_a = an_mag_ff;
                  case (func_ff)
                     FN_MUL:  mul_b = bn_mag_ff;
                     FN_NORM: mul_b = 32'd1;
                     default: mul_b = {1'b0, bd_ff};
                  endcase
                  psign_in = is_addsub_cmp ? an_neg_ff : (an_neg_ff ^
                             ((func_ff == FN_NORM) ? 1'b0 : bn_neg_ff));
               end
               2'd1: begin
                  mul_a    = bn_mag_ff;
                  mul_b    = ad_ff;
                  psign_in = bn_neg_ff;
               end
               default: begin
                  mul_a = ad_ff;
                  case (func_ff)
                     FN_DIV:  mul_b = bn_mag_ff;
                     FN_NORM: mul_b = 32'd1;
                     default: mul_b = {1'b0, bd_ff};
                  endcase
                  psign_in = 1'b0;
               end
            endcase
            p_in     = mul_p;
            state_in = S_SGN;
         end

         S_SGN: begin
            au_a    = '0;
            au_b    = {2'b00, p_ff};
            au_ctrl = '{sub: psign_ff};
            case (step_ff)
               2'd0: begin
                  x_in     = au_sum;
                  step_in  = 2'd1;
                  state_in = S_MUL;
               end
               2'd1: begin
                  y_in     = au_sum;
                  step_in  = 2'd2;
                  state_in = S_MUL;
               end
               default: begin
                  d_in     = au_sum[63:0];
                  state_in = S_COMB;
               end
            endcase
         end

         S_COMB: begin
            au_a = x_ff;
            au_b = is_addsub_cmp ? y_ff : '0;
            au_ctrl = '{sub: (func_ff != FN_ADD)};
            case (func_ff)
               FN_LT: cmp_res = au_sum[AW-1];
               FN_LE: cmp_res = au_sum[AW-1] || (au_sum == '0);
               FN_EQ: cmp_res = (au_sum == '0);
               FN_NE: cmp_res = (au_sum != '0);
               FN_GE: cmp_res = !au_sum[AW-1];
               FN_GT: cmp_res = !au_sum[AW-1] && (au_sum != '0);
               default: cmp_res = 1'b0;
            endcase
            if (func_ff inside {FN_LT, FN_LE, FN_EQ, FN_NE, FN_GE, FN_GT}) begin
               pend_in.cmp_true = cmp_res;
               state_in = S_OUT;
            end else begin
               x_in     = au_sum;
               state_in = S_ABS;
            end
         end

         S_ABS: begin
            au_a    = '0;
            au_b    = x_ff;
            au_ctrl = '{sub: x_ff[AW-1]};
            neg_in  = x_ff[AW-1];
            m_in    = au_sum[63:0];
            u_in    = au_sum[63:0];
            v_in    = d_ff;
            k_in    = '0;
            if (x_ff == '0) begin
               state_in = S_OUT;
            end else begin
               state_in = S_GCD;
            end
         end

         S_GCD: begin
            // Binary gcd; u reaching zero leaves the odd part of the gcd in v.
            au_a    = {2'b00, u_ff};
            au_b    = {2'b00, v_ff};
            au_ctrl = '{sub: 1'b1};
            if (u_ff == 64'd0) begin
               v_in     = v_ff << k_ff;
               rem_in   = '0;
               q_in     = m_ff;
               cnt_in   = '0;
               state_in = S_DIVN;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 6'd1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (au_sum[AW-1]) begin
               u_in = v_ff;
               v_in = u_ff;
            end else begin
               u_in = au_sum[64:1];
            end
         end

         S_DIVN, S_DIVD: begin
            // Restoring division by the gcd, one quotient bit per cycle.
            au_a    = {1'b0, div_t};
            au_b    = {2'b00, v_ff};
            au_ctrl = '{sub: 1'b1};
            if (au_sum[AW-1]) begin
               rem_in = div_t[63:0];
               q_in   = q_shift;
            end else begin
               rem_in = au_sum[63:0];
               q_in   = q_shift | 64'd1;
            end
            cnt_in = cnt_ff + 6'd1;
            if (div_last) begin
               cnt_in = '0;
               if (state_ff == S_DIVN) begin
                  m_in     = q_in;
                  rem_in   = '0;
                  q_in     = d_ff;
                  state_in = S_DIVD;
               end else begin
                  state_in = S_PACK;
               end
            end
         end

         S_PACK: begin
            au_a    = '0;
            au_b    = {2'b00, m_ff};
            au_ctrl = '{sub: neg_ff};
            if (m_ff > LIMIT || q_ff > LIMIT) begin
               pend_in.status = ST_OVF;
            end else begin
               pend_in.res_num = signed'(au_sum[31:0]);
               pend_in.res_den = q_ff[30:0];
            end
            state_in = S_OUT;
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff   <= func_in;
      an_mag_ff <= an_mag_in;
      an_neg_ff <= an_neg_in;
      bn_mag_ff <= bn_mag_in;
      bn_neg_ff <= bn_neg_in;
      ad_ff     <= ad_in;
      bd_ff     <= bd_in;
      step_ff   <= step_in;
      p_ff      <= p_in;
      psign_ff  <= psign_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      d_ff      <= d_in;
      neg_ff    <= neg_in;
      m_ff      <= m_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      k_ff      <= k_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   // An accepted request keeps the sequencer busy on the next cycle.
   `ASSERT_CLK(a_busy_after_req, req_fire |=> !req_chan.ready, "ready after accept")
   // The gcd divisor never reaches zero while the gcd runs.
   `ASSERT_CLK(a_gcd_v_nonzero, (state_ff == S_GCD) |-> (v_ff != 64'd0), "gcd v is zero")
   // Any error status and any true comparison carry the fraction 0/1.
   `ASSERT_CLK(a_err_zero, (rsp_chan.valid && (rsp_chan.status != ST_OK || rsp_chan.cmp_true))
      |-> (rsp_chan.res_num == 32'sd0 && rsp_chan.res_den == 31'd1), "error result not 0/1")
   // A valid response always carries a positive denominator.
   `ASSERT_CLK(a_den_pos, rsp_chan.valid |-> (rsp_chan.res_den != 31'd0), "zero denominator")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb
   import rau_pkg::*;
();

   // A request as the driver queues it.
   typedef struct {
      logic [3:0]         func;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } rat_req_type;

   // A response as the scoreboard holds it.
   typedef struct {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               cmp_true;
      logic [1:0]         status;
   } rat_rsp_type;

   localparam int LONG_HOLD = 300;

   logic clock;
   logic reset;

   rau_req_if req_chan ();
   rau_rsp_if rsp_chan ();

   rational_arithmetic_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rat_req_type pending_reqs[$];
   rat_rsp_type expected_fracs[$];
   int       error_count;
   bit       drain_pause;
   bit       req_taken;
   int       hold_cycles;
   int       burst_left;
   int       gap_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Greatest common divisor of two magnitudes by Euclid.
   function automatic logic [63:0] frac_gcd(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = y;
         y = x % y;
         x = t;
      end
      return x;
   endfunction

   function automatic logic [63:0] mag_of(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Reduce num/den with den positive, flagging a result that does not fit.
   function automatic rat_rsp_type reduce_frac(logic signed [63:0] num, logic [63:0] den);
      rat_rsp_type r;
      logic [63:0] m;
      logic [63:0] g;
      logic [63:0] lim;
      lim = 64'h7FFF_FFFF;
      r = '{0, 1, 1'b0, ST_OK};
      m = mag_of(num);
      if (m == 0) return r;
      g = frac_gcd(m, den);
      m = m / g;
      den = den / g;
      if (m > lim || den > lim) begin
         r.status = ST_OVF;
         return r;
      end
      r.res_num = num < 0 ? -m[31:0] : m[31:0];
      r.res_den = den[30:0];
      return r;
   endfunction

   // Predicts the response of one request.
   function automatic rat_rsp_type predict_rational(rat_req_type q);
      rat_rsp_type        r;
      logic signed [63:0] an;
      logic signed [63:0] bn;
      logic signed [63:0] ad;
      logic signed [63:0] bd;
      logic signed [63:0] lhs;
      logic signed [63:0] rhs;
      r = '{0, 1, 1'b0, ST_OK};
      an = q.a_num;
      bn = q.b_num;
      bd = {33'd0, q.b_den};
      if (q.func > FN_NORM) return r;
      if (q.a_den == 0 || (q.func != FN_NORM && q.b_den == 0)) begin
         r.status = ST_DIV0;
         return r;
      end
      ad = q.a_den;
      if (ad < 0) begin
         an = -an;
         ad = -ad;
      end
      lhs = an * bd;
      rhs = bn * ad;
      case (q.func)
         FN_ADD:  r = reduce_frac(lhs + rhs, ad * bd);
         FN_SUB:  r = reduce_frac(lhs - rhs, ad * bd);
         FN_MUL:  r = reduce_frac(an * bn, ad * bd);
         FN_DIV: begin
            if (bn == 0) r.status = ST_DIV0;
            else r = reduce_frac(bn < 0 ? -lhs : lhs, ad * mag_of(bn));
         end
         FN_NORM: r = reduce_frac(an, ad);
         FN_LT:   r.cmp_true = lhs < rhs;
         FN_LE:   r.cmp_true = lhs <= rhs;
         FN_EQ:   r.cmp_true = lhs == rhs;
         FN_NE:   r.cmp_true = lhs != rhs;
         FN_GE:   r.cmp_true = lhs >= rhs;
         default: r.cmp_true = lhs > rhs;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20) - 10;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sh7FFF_FFFF;
         3: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] rand_den();
      case ($urandom_range(0, 4))
         0: return 31'($urandom_range(1, 12));
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(1, 5000));
         3: return $urandom_range(0, 3) == 0 ? 31'd0 : 31'd1;
         default: return 31'($urandom);
      endcase
   endfunction

   task automatic add_req(logic [3:0] f, logic signed [31:0] an, logic signed [31:0] ad,
                          logic signed [31:0] bn, logic [30:0] bd);
      rat_req_type q;
      q = '{f, an, ad, bn, bd};
      pending_reqs.push_back(q);
   endtask

   // Remembers whether the offered request was taken at the last rising edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_chan.valid && req_chan.ready;
   end

   // Driver: bursts of requests separated by random gaps, changing at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
         // Hold the offered request until it is taken.
      end else begin
         if (req_chan.valid) void'(pending_reqs.pop_front());
         if (gap_left > 0) gap_left--;
         if (pending_reqs.size() == 0 || drain_pause || gap_left > 0) begin
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid <= 1'b1;
            req_chan.func  <= pending_reqs[0].func;
            req_chan.a_num <= pending_reqs[0].a_num;
            req_chan.a_den <= pending_reqs[0].a_den;
            req_chan.b_num <= pending_reqs[0].b_num;
            req_chan.b_den <= pending_reqs[0].b_den;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150);
            end
         end
      end
   end

   // Receiver stall pattern, with two long hold-offs to back the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Accepted requests feed the predictor; accepted responses are checked.
   always @(posedge clock) begin
      rat_req_type q;
      rat_rsp_type e;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            q = '{req_chan.func, req_chan.a_num, req_chan.a_den,
                  req_chan.b_num, req_chan.b_den};
            expected_fracs.push_back(predict_rational(q));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_fracs.size() == 0) begin
               report_mismatch("unexpected response", rsp_chan.res_num, 0);
            end else begin
               e = expected_fracs.pop_front();
               if (rsp_chan.res_num !== e.res_num)
                  report_mismatch("res_num", rsp_chan.res_num, e.res_num);
               if (rsp_chan.res_den !== e.res_den)
                  report_mismatch("res_den", rsp_chan.res_den, e.res_den);
               if (rsp_chan.cmp_true !== e.cmp_true)
                  report_mismatch("cmp_true", rsp_chan.cmp_true, e.cmp_true);
               if (rsp_chan.status !== e.status)
                  report_mismatch("status", rsp_chan.status, e.status);
            end
         end
      end
   end

   initial begin
      logic [3:0] f;
      error_count = 0;
      drain_pause = 0;
      hold_cycles = 0;
      burst_left = 0;
      gap_left = 0;
      req_chan.valid = 1'b0;
      req_chan.func = '0;
      req_chan.a_num = '0;
      req_chan.a_den = 1;
      req_chan.b_num = '0;
      req_chan.b_den = 1;
      rsp_chan.ready = 1'b0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: every code, the extremes, zero denominators, division by zero,
      // overflow, negative a denominator, unreduced operands and unused codes.
      for (int i = 0; i <= 10; i++) add_req(4'(i), 6, 4, -3, 9);
      add_req(FN_ADD, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1);
      add_req(FN_MUL, -32'sh7FFF_FFFF, 3, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
      add_req(FN_DIV, 5, 7, 0, 3);
      add_req(FN_DIV, 5, -7, -2, 3);
      add_req(FN_ADD, 1, 0, 1, 1);
      add_req(FN_SUB, 1, 2, 1, 0);
      add_req(FN_NORM, 8, -12, 0, 0);
      add_req(FN_NORM, 32'sh8000_0000, -1, 0, 0);
      add_req(FN_SUB, 3, 7, 3, 7);
      add_req(FN_EQ, 2, 4, 1, 2);
      add_req(FN_GT, -32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 1);
      add_req(4'd11, 1, 1, 1, 1);
      add_req(4'd15, -1, -1, -1, 31'h7FFF_FFFF);
      add_req(FN_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);

      // Long receiver hold-off while requests keep coming.
      hold_cycles = LONG_HOLD;
      wait (pending_reqs.size() == 0);

      // Sender pause until every response has arrived.
      drain_pause = 1;
      wait (expected_fracs.size() == 0);
      drain_pause = 0;

      for (int i = 0; i < 1350; i++) begin
         f = 4'($urandom_range(0, 15) == 0 ? $urandom_range(11, 15) :
                $urandom_range(0, 10));
         add_req(f, rand_word(), $urandom_range(0, 9) == 0 ? rand_word() :
                 $urandom_range(1, 1000), rand_word(), rand_den());
         if (i == 700) hold_cycles = LONG_HOLD;
         if (pending_reqs.size() > 40) wait (pending_reqs.size() < 10);
      end
      wait (pending_reqs.size() == 0);
      wait (expected_fracs.size() == 0);
      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
